// ----- rtl/kve_pkg.sv -----
// Package for the keyed line value extractor.
// Holds the state and result types, phase codes and the fixed prefix text.
// No dependencies.
package kve_pkg;

    localparam int unsigned MaxValueLen = 4096;
    localparam int unsigned PrefixLen   = 12;
    localparam int unsigned MaxKeyLen   = 8;

    localparam int unsigned ChW   = 8;
    localparam int unsigned PosW  = 13;
    localparam int unsigned IdxW  = 5;
    localparam int unsigned KeyW  = 64;
    localparam int unsigned KLenW = 4;

    // Phase codes of the line parser.
    localparam logic [2:0] PH_LINE_START = 3'd0;
    localparam logic [2:0] PH_MATCH      = 3'd1;
    localparam logic [2:0] PH_WAIT_COLON = 3'd2;
    localparam logic [2:0] PH_SKIP_BLANK = 3'd3;
    localparam logic [2:0] PH_CAPTURE    = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_KEY_NAME   = 1'b0;
    localparam logic CFG_KEY_LENGTH = 1'b1;

    localparam logic [ChW-1:0] CH_TAB   = 8'h09;
    localparam logic [ChW-1:0] CH_SPACE = 8'h20;
    localparam logic [ChW-1:0] CH_CR    = 8'h0D;
    localparam logic [ChW-1:0] CH_LF    = 8'h0A;
    localparam logic [ChW-1:0] CH_COLON = 8'h3A;

    typedef struct packed {
        logic [2:0]      phase;
        logic [IdxW-1:0] match_index;
        logic [PosW-1:0] captured_count;
        logic            line_good;
        logic            finished;
    } t_kve_state;

    typedef struct packed {
        logic            valid;
        logic [ChW-1:0]  value_byte;
        logic [PosW-1:0] position;
        logic            done_res;
    } t_kve_result;

    // Characters of the literal "destination." by position.
    function automatic logic [ChW-1:0] prefix_char(input logic [3:0] idx);
        logic [ChW-1:0] c;
        case (idx)
            4'd0:    c = 8'h64; // d
            4'd1:    c = 8'h65; // e
            4'd2:    c = 8'h73; // s
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h69; // i
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h61; // a
            4'd7:    c = 8'h74; // t
            4'd8:    c = 8'h69; // i
            4'd9:    c = 8'h6F; // o
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h2E; // .
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/kve_step.sv -----
// Next-state and result logic for one character of the line parser.
// Depends on kve_pkg.
module kve_step (
    input  logic [7:0]            i_ch,
    input  kve_pkg::t_kve_state   i_state,
    input  logic [63:0]           i_key_name,
    input  logic [3:0]            i_key_length,
    output kve_pkg::t_kve_state   o_state,
    output kve_pkg::t_kve_result  o_result
);

    logic                  is_blank;
    logic                  is_eol;
    logic [3:0]            eff_len;
    logic [2:0]            ph;
    logic [4:0]            k;
    logic [7:0]            kc;
    logic                  in_prefix;

    always_comb begin
        is_blank  = (i_ch == kve_pkg::CH_TAB) || (i_ch == kve_pkg::CH_SPACE);
        is_eol    = (i_ch == kve_pkg::CH_CR) || (i_ch == kve_pkg::CH_LF);
        in_prefix = (i_state.match_index < 5'(kve_pkg::PrefixLen));
        k         = i_state.match_index - 5'(kve_pkg::PrefixLen);
        kc        = i_key_name[{k[2:0], 3'b000} +: 8];

        if (i_key_length == 4'd0) begin
            eff_len = 4'd1;
        end else if (i_key_length > 4'(kve_pkg::MaxKeyLen)) begin
            eff_len = 4'(kve_pkg::MaxKeyLen);
        end else begin
            eff_len = i_key_length;
        end

        o_state             = i_state;
        o_result            = '0;
        ph                  = i_state.phase;

        if (i_state.finished) begin
            o_state = i_state;
        end else if (is_eol) begin
            if (i_state.captured_count != '0) begin
                o_state.finished    = 1'b1;
                o_result.valid      = 1'b1;
                o_result.position   = i_state.captured_count;
                o_result.done_res   = 1'b1;
            end else begin
                o_state.match_index = '0;
                o_state.line_good   = 1'b1;
                o_state.phase       = kve_pkg::PH_LINE_START;
            end
        end else if (i_state.line_good) begin
            if (ph == kve_pkg::PH_LINE_START && !is_blank) begin
                ph = kve_pkg::PH_MATCH;
            end

            case (ph)
                kve_pkg::PH_MATCH: begin
                    if (in_prefix) begin
                        if (i_ch == kve_pkg::prefix_char(i_state.match_index[3:0])) begin
                            o_state.match_index = i_state.match_index + 5'd1;
                        end else begin
                            o_state.line_good = 1'b0;
                        end
                    end else if (k < 5'(kve_pkg::MaxKeyLen) && k < {1'b0, eff_len}
                                 && i_ch == kc) begin
                        if (k + 5'd1 == {1'b0, eff_len}) begin
                            ph = kve_pkg::PH_WAIT_COLON;
                        end
                        o_state.match_index = i_state.match_index + 5'd1;
                    end else begin
                        o_state.line_good = 1'b0;
                    end
                end
                kve_pkg::PH_WAIT_COLON: begin
                    if (i_ch == kve_pkg::CH_COLON) begin
                        ph = kve_pkg::PH_SKIP_BLANK;
                    end
                end
                kve_pkg::PH_SKIP_BLANK: begin
                    if (!is_blank) begin
                        ph = kve_pkg::PH_CAPTURE;
                    end
                end
                default: begin
                    ph = ph;
                end
            endcase

            o_state.phase = ph;

            if (ph == kve_pkg::PH_CAPTURE
                && i_state.captured_count < 13'(kve_pkg::MaxValueLen)) begin
                o_result.valid         = 1'b1;
                o_result.value_byte    = i_ch;
                o_result.position      = i_state.captured_count;
                o_state.captured_count = i_state.captured_count + 13'd1;
            end
        end
    end

endmodule

// ----- rtl/keyed_line_value_extractor_unit.sv -----
// An accepted input item is held in the input register; its result item, if any, goes to the result register.
// One item per cycle while the result stream does not stall; the parser state is updated once per item.
// Reset (synchronous, active low) clears the parser state, both pipeline valids and
// sets key_name to zero and key_length to one.
// Top level of the keyed line value extractor; depends on kve_pkg and kve_step.
module keyed_line_value_extractor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] ch
    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,    // [7:0] value_byte, [20:8] position, [23:21] zero
    output logic        o_m_tlast,    // done_res
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic                  r_in_valid;
    logic [7:0]            r_in_ch;
    logic                  r_out_valid;
    logic [7:0]            r_out_byte;
    logic [12:0]           r_out_pos;
    logic                  r_out_done;
    logic [63:0]           r_key_name;
    logic [3:0]            r_key_length;
    kve_pkg::t_kve_state   r_state;
    kve_pkg::t_kve_state   n_state;
    kve_pkg::t_kve_result  n_result;
    logic                  advance;

    // The parse stage moves on when the result register is free or being drained.
    assign advance     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    kve_step u_step (
        .i_ch         (r_in_ch),
        .i_state      (r_state),
        .i_key_name   (r_key_name),
        .i_key_length (r_key_length),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_name   <= '0;
            r_key_length <= 4'd1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == kve_pkg::CFG_KEY_NAME) begin
                r_key_name <= i_cfg_data;
            end else begin
                r_key_length <= i_cfg_data[3:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready) begin
            r_in_ch <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase          <= kve_pkg::PH_LINE_START;
            r_state.match_index    <= '0;
            r_state.captured_count <= '0;
            r_state.line_good      <= 1'b1;
            r_state.finished       <= 1'b0;
            r_out_valid            <= 1'b0;
        end else begin
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= n_result.valid;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_out_byte <= n_result.value_byte;
            r_out_pos  <= n_result.position;
            r_out_done <= n_result.done_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_pos, r_out_byte};
    assign o_m_tlast  = r_out_done;

endmodule
